>>> hdl/rpss_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and sizes of the record/play step sequencer.
package rpss_pkg;

  // Store sizing
  localparam int MAX_STEPS = 128;
  localparam int IDX_W     = $clog2(MAX_STEPS);
  localparam int CNT_W     = $clog2(MAX_STEPS + 1);

  // Counter widths
  localparam int ST_W  = 20;
  localparam int SIL_W = 32;

  localparam logic [ST_W-1:0] STEP_TICKS_RESET = 20'd8000;

  // Command codes
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_NOTE  = 3'd1;
  localparam logic [2:0] CMD_IDLE  = 3'd2;
  localparam logic [2:0] CMD_REC   = 3'd3;
  localparam logic [2:0] CMD_PLAY  = 3'd4;
  localparam logic [2:0] CMD_CLEAR = 3'd5;

  // Mode codes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_REC  = 2'd1;
  localparam logic [1:0] MODE_PLAY = 2'd2;

  // Event codes
  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_ON   = 2'd1;
  localparam logic [1:0] EV_REL  = 2'd2;

  typedef struct packed {
    logic [2:0] command;
    logic [3:0] note;
    logic [3:0] octave;
    logic       tie;
    logic       voice_available;
  } in_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic [3:0] event_note;
    logic [3:0] event_octave;
    logic [1:0] mode_now;
    logic [7:0] step_count;
    logic [6:0] position;
    logic       last;
  } out_t;

  // One pending event of the current beat
  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] note;
    logic [3:0] octave;
  } ev_t;

  // One stored step
  typedef struct packed {
    logic       rest;
    logic       tie;
    logic [3:0] octave;
    logic [3:0] note;
  } entry_t;

endpackage

>>> hdl/record_play_step_sequencer_top.sv
`timescale 1ns / 1ps
// Step sequencer with record and play modes, driven by a small sequencer.
//
// Usage: pulse start with a command beat on in_data while busy is low; the
// beat is taken at that edge and busy rises for the whole command. Commands
// are tick, record note, go idle, go record, go play and clear.
// Each command gives one or two result beats on out_data, each marked by a
// one-cycle out_strobe; last flags the final beat of the command. The
// receiver cannot stall, so results are never held back.
// step_ticks is written through cfg_we/cfg_wdata while busy is low.
// Flow: a command keeps busy high until its final result beat is emitted, and
// the next command can be taken as soon as busy is low. A plain tick or mode
// change goes straight to the emit state, but a playback step or go-play first
// passes S_READ for the registered store read and then S_FIRE, a note or
// go-idle in record mode first passes S_FLUSH, and a second result beat repeats
// the emit state. The rest flush writes one rest step per cycle through the
// single store write port and one compare/subtract of the silence counter.
// Results are registered and follow in the cycle after their emit cycle.
// Reset (rst_n low, synchronous) sets idle mode, empty recording, position
// zero, no sounding voice and step_ticks 8000. The step store is not
// cleared: only steps recorded since the last go-record or clear are read.
module record_play_step_sequencer_top (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  rpss_pkg::in_t            in_data,
  output logic                     out_strobe,
  output rpss_pkg::out_t           out_data,
  input  logic                     cfg_we,
  input  logic [rpss_pkg::ST_W-1:0] cfg_wdata
);
  import rpss_pkg::*;

  localparam int         S_W     = 3;
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FLUSH = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_FIRE  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  // Step store
  entry_t mem [MAX_STEPS];
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  entry_t            mem_wd;

  logic [S_W-1:0]   state_r, state_nxt;
  logic [1:0]       mode_r, mode_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [IDX_W-1:0] pos_r, pos_nxt;
  logic [ST_W-1:0]  tick_cnt_r, tick_cnt_nxt;
  logic [SIL_W-1:0] sil_r, sil_nxt;
  logic             voice_r, voice_nxt;
  logic [ST_W-1:0]  step_ticks_r, step_ticks_nxt;
  in_t              item_r, item_nxt;
  logic             after_note_r, after_note_nxt;
  logic             adv_r, adv_nxt;
  logic [IDX_W-1:0] rd_addr_r, rd_addr_nxt;
  entry_t           rd_data_r;
  ev_t              ev_r [2];
  ev_t              ev_nxt [2];
  logic [1:0]       ev_cnt_r, ev_cnt_nxt;
  logic             emit_r, emit_nxt;
  logic             out_strobe_r, out_strobe_nxt;
  out_t             out_data_r, out_data_nxt;

  logic [ST_W-1:0]  tick_inc;
  logic [CNT_W-1:0] pos_inc;
  logic [IDX_W-1:0] pos_wrap;
  logic             len_full;
  logic             sil_ge;
  logic [SIL_W-1:0] sil_diff;
  logic             emit_last;

  // Shared arithmetic: tick increment, position wrap, store-full check, silence compare/subtract, last-beat flag
  assign tick_inc  = tick_cnt_r + ST_W'(1);
  assign pos_inc   = CNT_W'(pos_r) + CNT_W'(1);
  assign pos_wrap  = (pos_inc >= len_r) ? '0 : pos_inc[IDX_W-1:0];
  assign len_full  = (len_r >= CNT_W'(MAX_STEPS));
  assign sil_ge    = (sil_r >= SIL_W'(step_ticks_r));
  assign sil_diff  = sil_r - SIL_W'(step_ticks_r);
  assign emit_last = (ev_cnt_r == 2'd0) || ((2'({1'b0, emit_r}) + 2'd1) == ev_cnt_r);

  // Sequencer next state
  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    len_nxt        = len_r;
    pos_nxt        = pos_r;
    tick_cnt_nxt   = tick_cnt_r;
    sil_nxt        = sil_r;
    voice_nxt      = voice_r;
    step_ticks_nxt = cfg_we ? cfg_wdata : step_ticks_r;
    item_nxt       = item_r;
    after_note_nxt = after_note_r;
    adv_nxt        = adv_r;
    rd_addr_nxt    = rd_addr_r;
    ev_nxt         = ev_r;
    ev_cnt_nxt     = ev_cnt_r;
    emit_nxt       = emit_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_wa         = len_r[IDX_W-1:0];
    mem_wd         = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt   = in_data;
          ev_cnt_nxt = 2'd0;
          emit_nxt   = 1'b0;
          state_nxt  = S_EMIT;
          unique case (in_data.command)
            CMD_TICK: begin
              if (mode_r == MODE_PLAY) begin
                if (tick_inc >= step_ticks_r) begin
                  tick_cnt_nxt = '0;
                  if (len_r != '0) begin
                    pos_nxt     = pos_wrap;
                    rd_addr_nxt = pos_wrap;
                    adv_nxt     = 1'b1;
                    state_nxt   = S_READ;
                  end
                end else begin
                  tick_cnt_nxt = tick_inc;
                end
              end else if (mode_r == MODE_REC) begin
                if (sil_r != '1) sil_nxt = sil_r + SIL_W'(1);
              end
            end
            CMD_NOTE: begin
              if (mode_r == MODE_REC && !len_full) begin
                after_note_nxt = 1'b1;
                state_nxt      = S_FLUSH;
              end
            end
            CMD_IDLE: begin
              if (mode_r == MODE_REC) begin
                after_note_nxt = 1'b0;
                state_nxt      = S_FLUSH;
              end
              if (voice_r) begin
                ev_nxt[0]  = '{kind: EV_REL, note: 4'd0, octave: 4'd0};
                ev_cnt_nxt = 2'd1;
              end
              voice_nxt    = 1'b0;
              tick_cnt_nxt = '0;
              mode_nxt     = MODE_IDLE;
            end
            CMD_REC: begin
              if (voice_r) begin
                ev_nxt[0]  = '{kind: EV_REL, note: 4'd0, octave: 4'd0};
                ev_cnt_nxt = 2'd1;
              end
              voice_nxt    = 1'b0;
              len_nxt      = '0;
              pos_nxt      = '0;
              tick_cnt_nxt = '0;
              sil_nxt      = '0;
              mode_nxt     = MODE_REC;
            end
            CMD_PLAY: begin
              if (len_r != '0) begin
                if (voice_r) begin
                  ev_nxt[0]  = '{kind: EV_REL, note: 4'd0, octave: 4'd0};
                  ev_cnt_nxt = 2'd1;
                end
                voice_nxt    = 1'b0;
                pos_nxt      = '0;
                tick_cnt_nxt = '0;
                rd_addr_nxt  = '0;
                adv_nxt      = 1'b0;
                mode_nxt     = MODE_PLAY;
                state_nxt    = S_READ;
              end
            end
            CMD_CLEAR: begin
              len_nxt      = '0;
              pos_nxt      = '0;
              tick_cnt_nxt = '0;
              sil_nxt      = '0;
              mode_nxt     = MODE_IDLE;
              voice_nxt    = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      // Turn each full step of silence into a rest, one per cycle, then store the pending note
      S_FLUSH: begin
        if (sil_ge && !len_full) begin
          mem_we  = 1'b1;
          mem_wd  = '{rest: 1'b1, tie: 1'b0, octave: 4'd0, note: 4'd0};
          len_nxt = len_r + CNT_W'(1);
          sil_nxt = sil_diff;
        end else begin
          sil_nxt   = '0;
          state_nxt = S_EMIT;
          if (after_note_r && !len_full) begin
            mem_we  = 1'b1;
            mem_wd  = '{rest: 1'b0, tie: item_r.tie, octave: item_r.octave,
                        note: item_r.note};
            len_nxt = len_r + CNT_W'(1);
          end
        end
      end

      // Wait for the registered store read
      S_READ: begin
        state_nxt = S_FIRE;
      end

      // Act on the step just read
      S_FIRE: begin
        state_nxt = S_EMIT;
        if (adv_r && rd_data_r.rest) begin
          if (voice_r) begin
            ev_nxt[ev_cnt_nxt[0]] = '{kind: EV_REL, note: 4'd0, octave: 4'd0};
            ev_cnt_nxt            = ev_cnt_nxt + 2'd1;
          end
          voice_nxt = 1'b0;
        end else if (!adv_r || !rd_data_r.tie) begin
          if (adv_r && voice_r) begin
            ev_nxt[ev_cnt_nxt[0]] = '{kind: EV_REL, note: 4'd0, octave: 4'd0};
            ev_cnt_nxt            = ev_cnt_nxt + 2'd1;
          end
          voice_nxt = 1'b0;
          if (!rd_data_r.rest && item_r.voice_available) begin
            ev_nxt[ev_cnt_nxt[0]] = '{kind: EV_ON, note: rd_data_r.note,
                                      octave: rd_data_r.octave};
            ev_cnt_nxt            = ev_cnt_nxt + 2'd1;
            voice_nxt             = 1'b1;
          end
        end
      end

      // Send one result beat per cycle
      S_EMIT: begin
        out_strobe_nxt = 1'b1;
        if (ev_cnt_r == 2'd0) begin
          out_data_nxt.event_res    = EV_NONE;
          out_data_nxt.event_note   = 4'd0;
          out_data_nxt.event_octave = 4'd0;
        end else begin
          out_data_nxt.event_res    = ev_r[emit_r].kind;
          out_data_nxt.event_note   = ev_r[emit_r].note;
          out_data_nxt.event_octave = ev_r[emit_r].octave;
        end
        out_data_nxt.mode_now   = mode_r;
        out_data_nxt.step_count = 8'(len_r);
        out_data_nxt.position   = 7'(pos_r);
        out_data_nxt.last       = emit_last;
        if (emit_last) begin
          state_nxt = S_IDLE;
        end else begin
          emit_nxt = 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mode_r       <= MODE_IDLE;
      len_r        <= '0;
      pos_r        <= '0;
      tick_cnt_r   <= '0;
      sil_r        <= '0;
      voice_r      <= 1'b0;
      step_ticks_r <= STEP_TICKS_RESET;
      ev_cnt_r     <= 2'd0;
      emit_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      len_r        <= len_nxt;
      pos_r        <= pos_nxt;
      tick_cnt_r   <= tick_cnt_nxt;
      sil_r        <= sil_nxt;
      voice_r      <= voice_nxt;
      step_ticks_r <= step_ticks_nxt;
      ev_cnt_r     <= ev_cnt_nxt;
      emit_r       <= emit_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    after_note_r <= after_note_nxt;
    adv_r        <= adv_nxt;
    rd_addr_r    <= rd_addr_nxt;
    ev_r         <= ev_nxt;
    out_data_r   <= out_data_nxt;
  end

  // Store write port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
  end

  // Store read port, registered
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr_r];
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  // Every accepted command raises busy in the following cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  // Recorded length never exceeds the store
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= CNT_W'(MAX_STEPS))
    else $error("recorded length beyond store depth");

  // Playback only runs over a non-empty recording, inside its length
  a_play_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_PLAY) |-> (len_r != '0 && CNT_W'(pos_r) < len_r))
    else $error("play position outside recording");

  // The final beat of a command is never directly followed by another beat
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.last) |=> !out_strobe)
    else $error("result beat right after final beat");

endmodule

>>> verif/tb_record_play_step_sequencer_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the step sequencer: command beats in, predicted event beats checked.
module tb_record_play_step_sequencer_top;
  import rpss_pkg::*;

  localparam int              CLK_PERIOD     = 10;
  localparam int              RANDOM_ITEMS   = 450;
  localparam logic [2:0]      CMD_SPARE_A    = 3'd6;
  localparam logic [2:0]      CMD_SPARE_B    = 3'd7;
  localparam logic [ST_W-1:0] STEP_TICKS_MAX = '1;

  // Predicts the event beats of each command and checks the beats that come out
  class seq_event_scoreboard;
    entry_t           steps [MAX_STEPS];
    int unsigned      rec_len;
    int unsigned      play_pos;
    logic [ST_W-1:0]  tick_cnt;
    logic [ST_W-1:0]  step_ticks;
    logic [SIL_W-1:0] silence;
    logic [1:0]       mode;
    bit               sounding;
    ev_t              beat_events [$];
    out_t             expected_beats [$];
    int               errors;

    function new();
      clear_state();
      step_ticks = STEP_TICKS_RESET;
      errors = 0;
    endfunction

    function void clear_state();
      foreach (steps[i]) steps[i] = '0;
      rec_len  = 0;
      play_pos = 0;
      tick_cnt = '0;
      silence  = '0;
      mode     = MODE_IDLE;
      sounding = 1'b0;
    endfunction

    function void set_step_ticks(logic [ST_W-1:0] value);
      step_ticks = value;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    // Queue one event of the current command, two at most
    function void push_event(logic [1:0] kind, logic [3:0] n, logic [3:0] o);
      ev_t ev;
      if (beat_events.size() >= 2) return;
      ev.kind   = kind;
      ev.note   = n;
      ev.octave = o;
      beat_events.push_back(ev);
    endfunction

    function void release_voice();
      if (sounding) push_event(EV_REL, '0, '0);
      sounding = 1'b0;
    endfunction

    // Sound a stored step if it is a note and a voice is granted
    function void fire_step(int unsigned idx, logic avail);
      entry_t s;
      s = steps[idx % MAX_STEPS];
      sounding = 1'b0;
      if (s.rest || !avail) return;
      push_event(EV_ON, s.note, s.octave);
      sounding = 1'b1;
    endfunction

    // Turn each full step of silence into a rest, up to capacity
    function void flush_rests();
      logic [SIL_W-1:0] span;
      span = SIL_W'(step_ticks);
      while (silence >= span && rec_len < MAX_STEPS) begin
        steps[rec_len] = '0;
        steps[rec_len].rest = 1'b1;
        rec_len++;
        silence = silence - span;
      end
      silence = '0;
    endfunction

    // Move playback to the next step, wrapping at the recorded length
    function void step_forward(logic avail);
      int unsigned nxt;
      entry_t      s;
      if (rec_len == 0) return;
      nxt = (play_pos + 1) % rec_len;
      s = steps[nxt % MAX_STEPS];
      play_pos = nxt;
      if (s.rest) begin
        release_voice();
      end else if (!s.tie) begin
        release_voice();
        fire_step(nxt, avail);
      end
    endfunction

    // Apply one accepted command and queue the beats it must produce
    function void log_command(in_t it);
      out_t beat;
      beat_events.delete();
      case (it.command)
        CMD_TICK: begin
          if (mode == MODE_PLAY) begin
            tick_cnt = tick_cnt + 1'b1;
            if (tick_cnt >= step_ticks) begin
              tick_cnt = '0;
              step_forward(it.voice_available);
            end
          end else if (mode == MODE_REC) begin
            if (silence != '1) silence = silence + 1'b1;
          end
        end
        CMD_NOTE: begin
          if (mode == MODE_REC && rec_len < MAX_STEPS) begin
            flush_rests();
            if (rec_len < MAX_STEPS) begin
              steps[rec_len].rest   = 1'b0;
              steps[rec_len].tie    = it.tie;
              steps[rec_len].octave = it.octave;
              steps[rec_len].note   = it.note;
              rec_len++;
            end
          end
        end
        CMD_IDLE: begin
          if (mode == MODE_REC) flush_rests();
          release_voice();
          tick_cnt = '0;
          mode = MODE_IDLE;
        end
        CMD_REC: begin
          release_voice();
          rec_len  = 0;
          play_pos = 0;
          tick_cnt = '0;
          silence  = '0;
          mode     = MODE_REC;
        end
        CMD_PLAY: begin
          // nothing recorded: stay in the current mode
          if (rec_len != 0) begin
            release_voice();
            play_pos = 0;
            tick_cnt = '0;
            fire_step(0, it.voice_available);
            mode = MODE_PLAY;
          end
        end
        CMD_CLEAR: begin
          clear_state();
        end
        default: begin
          // spare codes do nothing
        end
      endcase
      if (beat_events.size() == 0) push_event(EV_NONE, '0, '0);
      foreach (beat_events[k]) begin
        beat.event_res    = beat_events[k].kind;
        beat.event_note   = beat_events[k].note;
        beat.event_octave = beat_events[k].octave;
        beat.mode_now     = mode;
        beat.step_count   = rec_len[7:0];
        beat.position     = play_pos[6:0];
        beat.last         = (k == beat_events.size() - 1);
        expected_beats.push_back(beat);
      end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] seen);
      if (seen !== want) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, seen);
        errors++;
      end
    endfunction

    // Check one result beat against the oldest prediction
    function void check_beat(out_t got);
      out_t exp_b;
      if (expected_beats.size() == 0) begin
        $display("%0t: result beat with nothing expected: expected none, actual %h",
                 $time, got);
        errors++;
        return;
      end
      exp_b = expected_beats.pop_front();
      compare_field("event_res", 8'(exp_b.event_res), 8'(got.event_res));
      compare_field("event_note", 8'(exp_b.event_note), 8'(got.event_note));
      compare_field("event_octave", 8'(exp_b.event_octave), 8'(got.event_octave));
      compare_field("mode_now", 8'(exp_b.mode_now), 8'(got.mode_now));
      compare_field("step_count", exp_b.step_count, got.step_count);
      compare_field("position", 8'(exp_b.position), 8'(got.position));
      compare_field("last", 8'(exp_b.last), 8'(got.last));
    endfunction
  endclass

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            start     = 1'b0;
  logic            busy;
  in_t             in_data   = '0;
  logic            out_strobe;
  out_t            out_data;
  logic            cfg_we    = 1'b0;
  logic [ST_W-1:0] cfg_wdata = '0;

  seq_event_scoreboard sb = new();
  int                  items_sent = 0;
  bit                  no_gaps    = 1'b0;

  record_play_step_sequencer_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Take every strobed result beat
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_strobe === 1'b1) sb.check_beat(out_data);
  end

  function automatic in_t item_of(logic [2:0] cmd, logic [3:0] n, logic [3:0] o,
                                  logic t, logic v);
    in_t it;
    it.command         = cmd;
    it.note            = n;
    it.octave          = o;
    it.tie             = t;
    it.voice_available = v;
    return it;
  endfunction

  function automatic in_t make_item(logic [2:0] cmd);
    return item_of(cmd, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endfunction

  // Drop start for a random gap, mostly none or short
  task automatic pause();
    int r;
    int n;
    r = $urandom_range(0, 19);
    if (no_gaps || r < 12) n = 0;
    else if (r < 18) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Offer one command beat and hold it until taken
  task automatic issue(in_t it);
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy !== 1'b0);
    sb.log_command(it);
    items_sent++;
    pause();
  endtask

  // Wait until every predicted beat has come and the block is idle
  task automatic settle();
    start <= 1'b0;
    while (sb.pending() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_step_ticks(logic [ST_W-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_step_ticks(value);
    cfg_we <= 1'b0;
  endtask

  task automatic noise();
    issue(make_item(3'($urandom_range(0, 7))));
  endtask

  // Hand-picked sequence over the corner cases
  task automatic directed_checks();
    write_step_ticks(ST_W'(1));
    // play with nothing recorded, note outside record, spare codes
    issue(make_item(CMD_PLAY));
    issue(make_item(CMD_NOTE));
    issue(make_item(CMD_SPARE_A));
    issue(make_item(CMD_SPARE_B));
    // record: note, two rests, tied note, plain note, trailing silence
    issue(make_item(CMD_REC));
    issue(item_of(CMD_NOTE, 4'hF, 4'hF, 1'b0, 1'b1));
    repeat (2) issue(make_item(CMD_TICK));
    issue(item_of(CMD_NOTE, 4'h0, 4'h0, 1'b1, 1'b0));
    issue(item_of(CMD_NOTE, 4'h5, 4'h3, 1'b0, 1'b1));
    issue(make_item(CMD_TICK));
    // play, restart while sounding, walk rests and tie, no free voice, wrap
    issue(item_of(CMD_PLAY, 4'h0, 4'h0, 1'b0, 1'b1));
    issue(item_of(CMD_PLAY, 4'hF, 4'hF, 1'b1, 1'b1));
    repeat (3) issue(item_of(CMD_TICK, 4'h0, 4'h0, 1'b0, 1'b1));
    issue(item_of(CMD_TICK, 4'hF, 4'hF, 1'b1, 1'b0));
    issue(item_of(CMD_TICK, 4'h0, 4'h0, 1'b0, 1'b1));
    issue(make_item(CMD_REC));
    // zero step length: flush fills the store, then notes are dropped
    write_step_ticks('0);
    issue(make_item(CMD_TICK));
    repeat (2) issue(item_of(CMD_NOTE, 4'hA, 4'h5, 1'b0, 1'b1));
    issue(make_item(CMD_IDLE));
    issue(item_of(CMD_PLAY, 4'h0, 4'h0, 1'b0, 1'b1));
    issue(item_of(CMD_TICK, 4'h0, 4'h0, 1'b0, 1'b1));
    issue(make_item(CMD_CLEAR));
  endtask

  // One record-then-play session with random content and some noise
  task automatic random_phase();
    int r;
    int notes;
    int run;
    r = $urandom_range(0, 11);
    if (r < 4) write_step_ticks(ST_W'(1));
    else if (r < 6) write_step_ticks(ST_W'(2));
    else if (r < 8) write_step_ticks(ST_W'($urandom_range(3, 6)));
    else if (r == 8) write_step_ticks(STEP_TICKS_MAX);
    else if (r == 9) write_step_ticks(ST_W'($urandom_range(1, STEP_TICKS_MAX)));
    else if (r == 10) write_step_ticks('0);
    no_gaps = ($urandom_range(0, 3) == 0);

    // record notes with runs of silence between them
    issue(make_item(CMD_REC));
    notes = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 140) : $urandom_range(1, 8);
    repeat (notes) begin
      run = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : $urandom_range(0, 2);
      repeat (run) issue(make_item(CMD_TICK));
      if ($urandom_range(0, 19) == 0) noise();
      issue(make_item(CMD_NOTE));
    end
    repeat ($urandom_range(0, 4)) issue(make_item(CMD_TICK));

    // leave record straight to play, through idle, or through clear
    r = $urandom_range(0, 9);
    if (r >= 5 && r < 9) issue(make_item(CMD_IDLE));
    else if (r == 9) issue(make_item(CMD_CLEAR));
    issue(make_item(CMD_PLAY));

    // play ticks, with the odd restart or stray command
    repeat ($urandom_range(4, 40)) begin
      r = $urandom_range(0, 19);
      if (r == 0) issue(make_item(CMD_PLAY));
      else if (r == 1) noise();
      else issue(make_item(CMD_TICK));
    end
    if ($urandom_range(0, 1) == 1) issue(make_item(CMD_IDLE));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_checks();
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) random_phase();
    settle();
    repeat (MAX_STEPS + 8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard limit on run time
  initial begin
    #25_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> filelist.f
hdl/rpss_pkg.sv
hdl/record_play_step_sequencer_top.sv
verif/tb_record_play_step_sequencer_top.sv
